### design/cabac_pkg.sv
`default_nettype none

package cabac_pkg;

  // Fixed coder widths
  localparam int unsigned LOW_W      = 20;
  localparam int unsigned RANGE_W    = 9;
  localparam int unsigned QCNT_W     = 5;
  localparam int unsigned RUN_CNT_W  = 5;
  localparam int unsigned RUNS_MAX   = 4;
  localparam int unsigned NRUNS_W    = 3;
  localparam int unsigned POS_OUT_W  = 24;
  localparam int unsigned CTX_W      = 7;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef logic [LOW_W-1:0]   low_t;
  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [QCNT_W-1:0]  qcnt_t;

  localparam range_t RANGE_RESET = 9'd510;
  // minus nine in two's complement
  localparam qcnt_t  QCNT_RESET  = 5'b10111;

  // Stop bit pattern, one bit per frame index
  localparam logic [31:0] STOP_PATTERN = 32'h35a4e4f5;

  typedef enum logic [1:0] {
    OP_DECISION  = 2'd0,
    OP_BYPASS    = 2'd1,
    OP_TERMINATE = 2'd2,
    OP_FINISH    = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // One resolved byte followed by count copies of a fill byte
  typedef struct packed {
    logic [7:0]           head;
    logic                 head_pre;
    logic [7:0]           fill;
    logic [RUN_CNT_W-1:0] count;
  } run_t;

  // Everything the back end needs to emit the results of one item
  typedef struct packed {
    run_t [RUNS_MAX-1:0]  runs;
    logic [NRUNS_W-1:0]   nruns;
    logic [CTX_W-1:0]     nst;
    logic [POS_OUT_W-1:0] pos;
    logic [1:0]           status;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE  = 3'd0,
    F_PUT   = 3'd1,
    F_ALIGN = 3'd2,
    F_FLUSH = 3'd3,
    F_PUSH  = 3'd4
  } front_state_t;

  typedef enum logic {
    BK_HEAD = 1'b0,
    BK_FILL = 1'b1
  } back_state_t;

  // LPS range, indexed by {probability index, range quarter}
  localparam logic [0:255][7:0] LPS_TAB = {
    8'd2, 8'd2, 8'd2, 8'd2, 8'd6, 8'd7, 8'd8, 8'd9,
    8'd6, 8'd7, 8'd9, 8'd10, 8'd6, 8'd8, 8'd9, 8'd11,
    8'd7, 8'd8, 8'd10, 8'd11, 8'd7, 8'd9, 8'd10, 8'd12,
    8'd7, 8'd9, 8'd11, 8'd12, 8'd8, 8'd9, 8'd11, 8'd13,
    8'd8, 8'd10, 8'd12, 8'd14, 8'd9, 8'd11, 8'd12, 8'd14,
    8'd9, 8'd11, 8'd13, 8'd15, 8'd10, 8'd12, 8'd14, 8'd16,
    8'd10, 8'd12, 8'd15, 8'd17, 8'd11, 8'd13, 8'd15, 8'd18,
    8'd11, 8'd14, 8'd16, 8'd19, 8'd12, 8'd14, 8'd17, 8'd20,
    8'd12, 8'd15, 8'd18, 8'd21, 8'd13, 8'd16, 8'd19, 8'd22,
    8'd14, 8'd17, 8'd20, 8'd23, 8'd14, 8'd18, 8'd21, 8'd24,
    8'd15, 8'd19, 8'd22, 8'd25, 8'd16, 8'd20, 8'd23, 8'd27,
    8'd17, 8'd21, 8'd25, 8'd28, 8'd18, 8'd22, 8'd26, 8'd30,
    8'd19, 8'd23, 8'd27, 8'd31, 8'd20, 8'd24, 8'd29, 8'd33,
    8'd21, 8'd26, 8'd30, 8'd35, 8'd22, 8'd27, 8'd32, 8'd37,
    8'd23, 8'd28, 8'd33, 8'd39, 8'd24, 8'd30, 8'd35, 8'd41,
    8'd26, 8'd31, 8'd37, 8'd43, 8'd27, 8'd33, 8'd39, 8'd45,
    8'd29, 8'd35, 8'd41, 8'd48, 8'd30, 8'd37, 8'd43, 8'd50,
    8'd32, 8'd39, 8'd46, 8'd53, 8'd33, 8'd41, 8'd48, 8'd56,
    8'd35, 8'd43, 8'd51, 8'd59, 8'd37, 8'd45, 8'd54, 8'd62,
    8'd39, 8'd48, 8'd56, 8'd65, 8'd41, 8'd50, 8'd59, 8'd69,
    8'd43, 8'd53, 8'd63, 8'd72, 8'd46, 8'd56, 8'd66, 8'd76,
    8'd48, 8'd59, 8'd69, 8'd80, 8'd51, 8'd62, 8'd73, 8'd85,
    8'd53, 8'd65, 8'd77, 8'd89, 8'd56, 8'd69, 8'd81, 8'd94,
    8'd59, 8'd72, 8'd86, 8'd99, 8'd62, 8'd76, 8'd90, 8'd104,
    8'd66, 8'd80, 8'd95, 8'd110, 8'd69, 8'd85, 8'd100, 8'd116,
    8'd73, 8'd89, 8'd105, 8'd122, 8'd77, 8'd94, 8'd111, 8'd128,
    8'd81, 8'd99, 8'd117, 8'd135, 8'd85, 8'd104, 8'd123, 8'd142,
    8'd90, 8'd110, 8'd130, 8'd150, 8'd95, 8'd116, 8'd137, 8'd158,
    8'd100, 8'd122, 8'd144, 8'd166, 8'd105, 8'd128, 8'd152, 8'd175,
    8'd111, 8'd135, 8'd160, 8'd185, 8'd116, 8'd142, 8'd169, 8'd195,
    8'd123, 8'd150, 8'd178, 8'd205, 8'd128, 8'd158, 8'd187, 8'd216,
    8'd128, 8'd167, 8'd197, 8'd227, 8'd128, 8'd176, 8'd208, 8'd240
  };

  // Context transition, indexed by {state, bin}
  localparam logic [0:255][6:0] NEXT_TAB = {
    7'd0, 7'd0, 7'd1, 7'd1, 7'd2, 7'd50, 7'd51, 7'd3,
    7'd2, 7'd50, 7'd51, 7'd3, 7'd4, 7'd52, 7'd53, 7'd5,
    7'd6, 7'd52, 7'd53, 7'd7, 7'd8, 7'd52, 7'd53, 7'd9,
    7'd10, 7'd54, 7'd55, 7'd11, 7'd12, 7'd54, 7'd55, 7'd13,
    7'd14, 7'd54, 7'd55, 7'd15, 7'd16, 7'd56, 7'd57, 7'd17,
    7'd18, 7'd56, 7'd57, 7'd19, 7'd20, 7'd56, 7'd57, 7'd21,
    7'd22, 7'd58, 7'd59, 7'd23, 7'd24, 7'd58, 7'd59, 7'd25,
    7'd26, 7'd60, 7'd61, 7'd27, 7'd28, 7'd60, 7'd61, 7'd29,
    7'd30, 7'd60, 7'd61, 7'd31, 7'd32, 7'd62, 7'd63, 7'd33,
    7'd34, 7'd62, 7'd63, 7'd35, 7'd36, 7'd64, 7'd65, 7'd37,
    7'd38, 7'd66, 7'd67, 7'd39, 7'd40, 7'd66, 7'd67, 7'd41,
    7'd42, 7'd66, 7'd67, 7'd43, 7'd44, 7'd68, 7'd69, 7'd45,
    7'd46, 7'd68, 7'd69, 7'd47, 7'd48, 7'd70, 7'd71, 7'd49,
    7'd50, 7'd72, 7'd73, 7'd51, 7'd52, 7'd72, 7'd73, 7'd53,
    7'd54, 7'd74, 7'd75, 7'd55, 7'd56, 7'd74, 7'd75, 7'd57,
    7'd58, 7'd76, 7'd77, 7'd59, 7'd60, 7'd78, 7'd79, 7'd61,
    7'd62, 7'd78, 7'd79, 7'd63, 7'd64, 7'd80, 7'd81, 7'd65,
    7'd66, 7'd82, 7'd83, 7'd67, 7'd68, 7'd82, 7'd83, 7'd69,
    7'd70, 7'd84, 7'd85, 7'd71, 7'd72, 7'd84, 7'd85, 7'd73,
    7'd74, 7'd88, 7'd89, 7'd75, 7'd76, 7'd88, 7'd89, 7'd77,
    7'd78, 7'd90, 7'd91, 7'd79, 7'd80, 7'd90, 7'd91, 7'd81,
    7'd82, 7'd94, 7'd95, 7'd83, 7'd84, 7'd94, 7'd95, 7'd85,
    7'd86, 7'd96, 7'd97, 7'd87, 7'd88, 7'd96, 7'd97, 7'd89,
    7'd90, 7'd100, 7'd101, 7'd91, 7'd92, 7'd100, 7'd101, 7'd93,
    7'd94, 7'd102, 7'd103, 7'd95, 7'd96, 7'd104, 7'd105, 7'd97,
    7'd98, 7'd104, 7'd105, 7'd99, 7'd100, 7'd108, 7'd109, 7'd101,
    7'd102, 7'd108, 7'd109, 7'd103, 7'd104, 7'd110, 7'd111, 7'd105,
    7'd106, 7'd112, 7'd113, 7'd107, 7'd108, 7'd114, 7'd115, 7'd109,
    7'd110, 7'd116, 7'd117, 7'd111, 7'd112, 7'd118, 7'd119, 7'd113,
    7'd114, 7'd118, 7'd119, 7'd115, 7'd116, 7'd122, 7'd123, 7'd117,
    7'd118, 7'd122, 7'd123, 7'd119, 7'd120, 7'd124, 7'd125, 7'd121,
    7'd122, 7'd126, 7'd127, 7'd123, 7'd124, 7'd127, 7'd126, 7'd125
  };

  function automatic logic [7:0] lps_range(input logic [5:0] pidx, input logic [1:0] quarter);
    return LPS_TAB[{pidx, quarter}];
  endfunction

  function automatic logic [CTX_W-1:0] next_ctx(input logic [CTX_W-1:0] st, input logic b);
    return NEXT_TAB[{st, b}];
  endfunction

  // Renormalization shift from range bits 8..3
  function automatic logic [2:0] renorm_shift(input logic [5:0] idx);
    logic [2:0] s;
    if (idx[5]) begin
      s = 3'd0;
    end else if (idx[4]) begin
      s = 3'd1;
    end else if (idx[3]) begin
      s = 3'd2;
    end else if (idx[2]) begin
      s = 3'd3;
    end else if (idx[1]) begin
      s = 3'd4;
    end else if (idx[0]) begin
      s = 3'd5;
    end else begin
      s = 3'd6;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### design/cabac_ifs.sv
`default_nettype none

// Operation channel
interface cabac_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       bin;
  logic [6:0] ctx_state;
  logic [4:0] frame_index;

  modport source(output valid, output op, output bin, output ctx_state, output frame_index,
                 input ready);
  modport sink(input valid, input op, input bin, input ctx_state, input frame_index,
               output ready);
endinterface

// Result channel
interface cabac_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        is_preceding;
  logic [6:0]  new_ctx_state;
  logic [23:0] byte_position;
  logic [1:0]  status;
  logic        last;

  modport source(output valid, output out_byte, output byte_valid, output is_preceding,
                 output new_ctx_state, output byte_position, output status, output last,
                 input ready);
  modport sink(input valid, input out_byte, input byte_valid, input is_preceding,
               input new_ctx_state, input byte_position, input status, input last,
               output ready);
endinterface

`default_nettype wire

### design/cabac_front.sv
`default_nettype none

module cabac_front #(
  parameter int unsigned OUTSTANDING_MAX = 16,
  parameter int unsigned POSITION_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  cabac_cmd_if.sink             cmd,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output cabac_pkg::entry_t     q_wdata
);

  localparam int unsigned OUT_W = $clog2(OUTSTANDING_MAX + 1);

  cabac_pkg::front_state_t state, state_next;

  cabac_pkg::low_t         low, low_next;
  cabac_pkg::range_t       rng, rng_next;
  cabac_pkg::qcnt_t        qcnt, qcnt_next;
  logic [OUT_W-1:0]        outst, outst_next;
  logic [7:0]              pending, pending_next;
  logic                    pend_pre, pend_pre_next;
  logic                    finished, finished_next;
  logic [POSITION_BITS-1:0] counter, counter_next;
  cabac_pkg::entry_t       item, item_next;
  logic                    is_fin, is_fin_next;
  logic                    fin_bit, fin_bit_next;
  logic [1:0]              put_idx, put_idx_next;
  logic                    done;

  // Byte extraction from low
  logic [4:0]        put_sh;
  cabac_pkg::low_t   low_shr;
  logic [9:0]        put_v;
  cabac_pkg::low_t   put_keep;
  logic              put_ok;
  logic              put_ff;
  logic [1:0]        carry;

  assign put_sh   = 5'(qcnt[3:0]) + 5'd10;
  assign low_shr  = low >> put_sh;
  assign put_v    = low_shr[9:0];
  assign put_keep = low & ((cabac_pkg::low_t'(1) << put_sh) - cabac_pkg::low_t'(1));
  assign put_ok   = !qcnt[4];
  assign put_ff   = (put_v[7:0] == 8'hFF);
  assign carry    = put_v[9:8];

  // Interval update for decision and terminate bins
  logic [7:0]        lps;
  cabac_pkg::range_t rmps;
  logic              lps_path;
  cabac_pkg::low_t   dec_low;
  cabac_pkg::range_t dec_rng;
  cabac_pkg::range_t norm_rng;
  cabac_pkg::low_t   norm_low;
  logic [2:0]        norm_sh;
  logic              is_term;

  assign lps      = cabac_pkg::lps_range(cmd.ctx_state[6:1], rng[7:6]);
  assign rmps     = rng - cabac_pkg::range_t'(lps);
  assign lps_path = (cmd.bin != cmd.ctx_state[0]);
  assign dec_low  = lps_path ? (low + cabac_pkg::low_t'(rmps)) : low;
  assign dec_rng  = lps_path ? cabac_pkg::range_t'(lps) : rmps;
  assign is_term  = (cmd.op == cabac_pkg::OP_TERMINATE);
  assign norm_rng = is_term ? (rng - 9'd2) : dec_rng;
  assign norm_low = is_term ? low : dec_low;
  assign norm_sh  = cabac_pkg::renorm_shift(norm_rng[8:3]);

  // Flush preparation and stop-bit alignment
  cabac_pkg::low_t fin_low;
  logic [4:0]      al_sh;
  cabac_pkg::low_t al_low;

  assign fin_low = ((low + cabac_pkg::low_t'(rng) - cabac_pkg::low_t'(2))
                    | cabac_pkg::low_t'(1)) << 9;
  assign al_sh   = qcnt[4] ? (~qcnt + 5'd1) : 5'd0;
  assign al_low  = (low << al_sh) | (cabac_pkg::low_t'(fin_bit) << 10);

  // Item completes in this cycle
  always_comb begin
    case (state)
      cabac_pkg::F_IDLE:  done = cmd.valid && finished;
      cabac_pkg::F_PUT:   done = !is_fin;
      cabac_pkg::F_FLUSH: done = 1'b1;
      default:            done = 1'b0;
    endcase
  end

  assign cmd.ready = (state == cabac_pkg::F_IDLE);
  assign q_push    = (done || (state == cabac_pkg::F_PUSH)) && !q_full;
  assign q_wdata   = item_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cabac_pkg::F_IDLE: begin
        if (cmd.valid) begin
          if (finished) begin
            state_next = q_full ? cabac_pkg::F_PUSH : cabac_pkg::F_IDLE;
          end else begin
            state_next = cabac_pkg::F_PUT;
          end
        end
      end
      cabac_pkg::F_PUT: begin
        if (!is_fin) begin
          state_next = q_full ? cabac_pkg::F_PUSH : cabac_pkg::F_IDLE;
        end else if (put_idx == 2'd0) begin
          state_next = cabac_pkg::F_PUT;
        end else if (put_idx == 2'd1) begin
          state_next = cabac_pkg::F_ALIGN;
        end else begin
          state_next = cabac_pkg::F_FLUSH;
        end
      end
      cabac_pkg::F_ALIGN: state_next = cabac_pkg::F_PUT;
      cabac_pkg::F_FLUSH: state_next = q_full ? cabac_pkg::F_PUSH : cabac_pkg::F_IDLE;
      cabac_pkg::F_PUSH:  state_next = q_full ? cabac_pkg::F_PUSH : cabac_pkg::F_IDLE;
      default:            state_next = cabac_pkg::F_IDLE;
    endcase
  end

  // Coder datapath
  always_comb begin
    low_next      = low;
    rng_next      = rng;
    qcnt_next     = qcnt;
    outst_next    = outst;
    pending_next  = pending;
    pend_pre_next = pend_pre;
    finished_next = finished;
    counter_next  = counter;
    item_next     = item;
    is_fin_next   = is_fin;
    fin_bit_next  = fin_bit;
    put_idx_next  = put_idx;

    case (state)
      cabac_pkg::F_IDLE: begin
        if (cmd.valid) begin
          item_next.nruns  = '0;
          item_next.nst    = cmd.ctx_state;
          item_next.status = cabac_pkg::STATUS_OK;
          is_fin_next      = 1'b0;
          put_idx_next     = '0;
          if (finished) begin
            item_next.status = cabac_pkg::STATUS_REJECTED;
          end else begin
            case (cabac_pkg::op_t'(cmd.op))
              cabac_pkg::OP_DECISION, cabac_pkg::OP_TERMINATE: begin
                if (!is_term) begin
                  item_next.nst = cabac_pkg::next_ctx(cmd.ctx_state, cmd.bin);
                end
                rng_next  = norm_rng << norm_sh;
                low_next  = norm_low << norm_sh;
                qcnt_next = qcnt + 5'(norm_sh);
              end
              cabac_pkg::OP_BYPASS: begin
                low_next  = (low << 1) + (cmd.bin ? cabac_pkg::low_t'(rng) : '0);
                qcnt_next = qcnt + 5'd1;
              end
              cabac_pkg::OP_FINISH: begin
                low_next     = fin_low;
                qcnt_next    = qcnt + 5'd9;
                is_fin_next  = 1'b1;
                fin_bit_next = cabac_pkg::STOP_PATTERN[cmd.frame_index];
              end
              default: ;
            endcase
          end
        end
      end

      // Extract one byte; hold 0xFF bytes as outstanding, resolve the rest
      cabac_pkg::F_PUT: begin
        put_idx_next = put_idx + 2'd1;
        if (put_ok) begin
          qcnt_next = qcnt - 5'd8;
          low_next  = put_keep;
          if (put_ff) begin
            if (outst < OUT_W'(OUTSTANDING_MAX)) begin
              outst_next = outst + OUT_W'(1);
            end else begin
              item_next.status = cabac_pkg::STATUS_OVERFLOW;
            end
          end else begin
            item_next.runs[item.nruns[1:0]] = '{
              head:     pending + 8'(carry),
              head_pre: pend_pre,
              fill:     8'(carry) - 8'd1,
              count:    cabac_pkg::RUN_CNT_W'(outst)
            };
            item_next.nruns = item.nruns + 3'd1;
            counter_next    = counter + POSITION_BITS'(outst) + POSITION_BITS'(1);
            outst_next      = '0;
            pending_next    = put_v[7:0];
            pend_pre_next   = 1'b0;
          end
        end
      end

      cabac_pkg::F_ALIGN: begin
        low_next  = al_low;
        qcnt_next = '0;
      end

      // Release the held byte and any outstanding 0xFF bytes
      cabac_pkg::F_FLUSH: begin
        item_next.runs[item.nruns[1:0]] = '{
          head:     pending,
          head_pre: pend_pre,
          fill:     8'hFF,
          count:    cabac_pkg::RUN_CNT_W'(outst)
        };
        item_next.nruns = item.nruns + 3'd1;
        counter_next    = counter + POSITION_BITS'(outst);
        outst_next      = '0;
        finished_next   = 1'b1;
      end

      default: ;
    endcase

    // Preceding byte write lands on the held byte until payload starts
    if (cfg_we && pend_pre) begin
      pending_next = cfg_data;
    end

    item_next.pos = cabac_pkg::POS_OUT_W'(counter_next + POSITION_BITS'(outst_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cabac_pkg::F_IDLE;
      low      <= '0;
      rng      <= cabac_pkg::RANGE_RESET;
      qcnt     <= cabac_pkg::QCNT_RESET;
      outst    <= '0;
      pending  <= '0;
      pend_pre <= 1'b1;
      finished <= 1'b0;
      counter  <= '0;
      is_fin   <= 1'b0;
      put_idx  <= '0;
    end else begin
      state    <= state_next;
      low      <= low_next;
      rng      <= rng_next;
      qcnt     <= qcnt_next;
      outst    <= outst_next;
      pending  <= pending_next;
      pend_pre <= pend_pre_next;
      finished <= finished_next;
      counter  <= counter_next;
      is_fin   <= is_fin_next;
      put_idx  <= put_idx_next;
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    item    <= item_next;
    fin_bit <= fin_bit_next;
  end

endmodule

`default_nettype wire

### design/cabac_fifo.sv
`default_nettype none

module cabac_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cabac_pkg::entry_t wdata,
  output logic              full,
  input  logic              pop,
  output cabac_pkg::entry_t head,
  output logic              empty
);

  localparam int unsigned PTR_W = $clog2(cabac_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(cabac_pkg::FIFO_DEPTH + 1);

  cabac_pkg::entry_t slots [cabac_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full  = (fill == CNT_W'(cabac_pkg::FIFO_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Store a transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(cabac_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(cabac_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/cabac_back.sv
`default_nettype none

module cabac_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cabac_pkg::entry_t q_head,
  output logic              q_pop,
  cabac_res_if.source       res
);

  cabac_pkg::back_state_t bstate, bstate_next;

  logic [1:0]                     ridx, ridx_next;
  logic [cabac_pkg::RUN_CNT_W-1:0] fill_left, fill_left_next;

  cabac_pkg::run_t run;
  logic            last_run;
  logic            no_runs;
  logic            load;
  logic            run_end;
  logic [7:0]      r_byte;
  logic            r_bv;
  logic            r_pre;
  logic            r_last;

  // Output register
  logic        ovalid;
  logic [7:0]  obyte;
  logic        obv;
  logic        opre;
  logic [6:0]  onst;
  logic [23:0] opos;
  logic [1:0]  ostatus;
  logic        olast;

  assign run      = q_head.runs[ridx];
  assign no_runs  = (q_head.nruns == '0);
  assign last_run = (({1'b0, ridx} + 3'd1) == q_head.nruns);
  assign load     = !q_empty && (!ovalid || res.ready);

  // Select the next result of the head transaction
  always_comb begin
    r_byte  = '0;
    r_bv    = 1'b0;
    r_pre   = 1'b0;
    r_last  = 1'b1;
    run_end = 1'b1;
    if (!no_runs) begin
      case (bstate)
        cabac_pkg::BK_HEAD: begin
          r_byte  = run.head;
          r_bv    = 1'b1;
          r_pre   = run.head_pre;
          run_end = (run.count == '0);
          r_last  = last_run && run_end;
        end
        cabac_pkg::BK_FILL: begin
          r_byte  = run.fill;
          r_bv    = 1'b1;
          run_end = (fill_left == cabac_pkg::RUN_CNT_W'(1));
          r_last  = last_run && run_end;
        end
        default: ;
      endcase
    end
  end

  assign q_pop = load && r_last;

  // Next state
  always_comb begin
    bstate_next = bstate;
    case (bstate)
      cabac_pkg::BK_HEAD: begin
        if (load && !no_runs && (run.count != '0)) begin
          bstate_next = cabac_pkg::BK_FILL;
        end
      end
      cabac_pkg::BK_FILL: begin
        if (load && run_end) begin
          bstate_next = cabac_pkg::BK_HEAD;
        end
      end
      default: bstate_next = cabac_pkg::BK_HEAD;
    endcase
  end

  // Run index and fill counter
  always_comb begin
    ridx_next      = ridx;
    fill_left_next = fill_left;
    if (load) begin
      if (r_last) begin
        ridx_next = '0;
      end else if (run_end) begin
        ridx_next = ridx + 2'd1;
      end
      if (bstate == cabac_pkg::BK_HEAD) begin
        fill_left_next = run.count;
      end else begin
        fill_left_next = fill_left - cabac_pkg::RUN_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= cabac_pkg::BK_HEAD;
      ridx   <= '0;
      ovalid <= 1'b0;
    end else begin
      bstate <= bstate_next;
      ridx   <= ridx_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (res.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Hold result payload until taken
  always_ff @(posedge clk) begin
    fill_left <= fill_left_next;
    if (load) begin
      obyte   <= r_byte;
      obv     <= r_bv;
      opre    <= r_pre;
      onst    <= q_head.nst;
      opos    <= q_head.pos;
      ostatus <= q_head.status;
      olast   <= r_last;
    end
  end

  assign res.valid         = ovalid;
  assign res.out_byte      = obyte;
  assign res.byte_valid    = obv;
  assign res.is_preceding  = opre;
  assign res.new_ctx_state = onst;
  assign res.byte_position = opos;
  assign res.status        = ostatus;
  assign res.last          = olast;

endmodule

`default_nettype wire

### design/cabac_binary_arithmetic_encoder_core.sv
// Channel   Dir  Handshake      Payload
// cmd       in   valid/ready    op, bin, ctx_state, frame_index
// res       out  valid/ready    out_byte, byte_valid, is_preceding, new_ctx_state,
//                               byte_position, status, last
// cfg       in   cfg_we         cfg_data (preceding byte)
//
// The coder front updates the interval in IDLE and extracts a byte in PUT for a decision, bypass
// or terminate bin; a finish runs PUT, PUT, ALIGN, PUT, FLUSH, and an item rejected after finish
// is queued straight from IDLE. The result side gives one transaction per cycle while res.ready holds.
// A two-entry queue between them lets the coder run ahead while results stall.
// Synchronous reset restarts the coder; no clearing pass is needed.
`default_nettype none

module cabac_binary_arithmetic_encoder_core #(
  parameter int unsigned OUTSTANDING_MAX = 16,
  parameter int unsigned POSITION_BITS   = 24
) (
  input  logic         clk,
  input  logic         rst,
  cabac_cmd_if.sink    cmd,
  cabac_res_if.source  res,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  cabac_pkg::entry_t q_wdata;
  cabac_pkg::entry_t q_head;

  // Coder: arithmetic, byte extraction, carry bookkeeping
  cabac_front #(
    .OUTSTANDING_MAX (OUTSTANDING_MAX),
    .POSITION_BITS   (POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Per-item queue
  cabac_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  // Result expansion
  cabac_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire

### bench/cabac_stream_checker.sv
module cabac_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  cabac_cmd_if        cmd,
  cabac_res_if        res,
  output int          mismatch_count,
  output int          results_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OUTSTANDING_LIMIT = 16;
  localparam logic [31:0] POS_MASK          = 32'h00FF_FFFF;
  localparam logic [31:0] STOP_BITS         = 32'h35a4_e4f5;
  localparam int          MAX_PER_ITEM      = 24;

  // LPS subrange per probability index and range quarter
  localparam logic [7:0] LPS_RANGE [64][4] = '{
    '{2, 2, 2, 2}, '{6, 7, 8, 9}, '{6, 7, 9, 10}, '{6, 8, 9, 11},
    '{7, 8, 10, 11}, '{7, 9, 10, 12}, '{7, 9, 11, 12}, '{8, 9, 11, 13},
    '{8, 10, 12, 14}, '{9, 11, 12, 14}, '{9, 11, 13, 15}, '{10, 12, 14, 16},
    '{10, 12, 15, 17}, '{11, 13, 15, 18}, '{11, 14, 16, 19}, '{12, 14, 17, 20},
    '{12, 15, 18, 21}, '{13, 16, 19, 22}, '{14, 17, 20, 23}, '{14, 18, 21, 24},
    '{15, 19, 22, 25}, '{16, 20, 23, 27}, '{17, 21, 25, 28}, '{18, 22, 26, 30},
    '{19, 23, 27, 31}, '{20, 24, 29, 33}, '{21, 26, 30, 35}, '{22, 27, 32, 37},
    '{23, 28, 33, 39}, '{24, 30, 35, 41}, '{26, 31, 37, 43}, '{27, 33, 39, 45},
    '{29, 35, 41, 48}, '{30, 37, 43, 50}, '{32, 39, 46, 53}, '{33, 41, 48, 56},
    '{35, 43, 51, 59}, '{37, 45, 54, 62}, '{39, 48, 56, 65}, '{41, 50, 59, 69},
    '{43, 53, 63, 72}, '{46, 56, 66, 76}, '{48, 59, 69, 80}, '{51, 62, 73, 85},
    '{53, 65, 77, 89}, '{56, 69, 81, 94}, '{59, 72, 86, 99}, '{62, 76, 90, 104},
    '{66, 80, 95, 110}, '{69, 85, 100, 116}, '{73, 89, 105, 122}, '{77, 94, 111, 128},
    '{81, 99, 117, 135}, '{85, 104, 123, 142}, '{90, 110, 130, 150}, '{95, 116, 137, 158},
    '{100, 122, 144, 166}, '{105, 128, 152, 175}, '{111, 135, 160, 185}, '{116, 142, 169, 195},
    '{123, 150, 178, 205}, '{128, 158, 187, 216}, '{128, 167, 197, 227}, '{128, 176, 208, 240}
  };

  // Context state transition per coded bin
  localparam logic [6:0] NEXT_STATE [128][2] = '{
    '{0, 0}, '{1, 1}, '{2, 50}, '{51, 3}, '{2, 50}, '{51, 3}, '{4, 52}, '{53, 5},
    '{6, 52}, '{53, 7}, '{8, 52}, '{53, 9}, '{10, 54}, '{55, 11}, '{12, 54}, '{55, 13},
    '{14, 54}, '{55, 15}, '{16, 56}, '{57, 17}, '{18, 56}, '{57, 19}, '{20, 56}, '{57, 21},
    '{22, 58}, '{59, 23}, '{24, 58}, '{59, 25}, '{26, 60}, '{61, 27}, '{28, 60}, '{61, 29},
    '{30, 60}, '{61, 31}, '{32, 62}, '{63, 33}, '{34, 62}, '{63, 35}, '{36, 64}, '{65, 37},
    '{38, 66}, '{67, 39}, '{40, 66}, '{67, 41}, '{42, 66}, '{67, 43}, '{44, 68}, '{69, 45},
    '{46, 68}, '{69, 47}, '{48, 70}, '{71, 49}, '{50, 72}, '{73, 51}, '{52, 72}, '{73, 53},
    '{54, 74}, '{75, 55}, '{56, 74}, '{75, 57}, '{58, 76}, '{77, 59}, '{60, 78}, '{79, 61},
    '{62, 78}, '{79, 63}, '{64, 80}, '{81, 65}, '{66, 82}, '{83, 67}, '{68, 82}, '{83, 69},
    '{70, 84}, '{85, 71}, '{72, 84}, '{85, 73}, '{74, 88}, '{89, 75}, '{76, 88}, '{89, 77},
    '{78, 90}, '{91, 79}, '{80, 90}, '{91, 81}, '{82, 94}, '{95, 83}, '{84, 94}, '{95, 85},
    '{86, 96}, '{97, 87}, '{88, 96}, '{97, 89}, '{90, 100}, '{101, 91}, '{92, 100}, '{101, 93},
    '{94, 102}, '{103, 95}, '{96, 104}, '{105, 97}, '{98, 104}, '{105, 99}, '{100, 108},
    '{109, 101}, '{102, 108}, '{109, 103}, '{104, 110}, '{111, 105}, '{106, 112}, '{113, 107},
    '{108, 114}, '{115, 109}, '{110, 116}, '{117, 111}, '{112, 118}, '{119, 113}, '{114, 118},
    '{119, 115}, '{116, 122}, '{123, 117}, '{118, 122}, '{123, 119}, '{120, 124}, '{125, 121},
    '{122, 126}, '{127, 123}, '{124, 127}, '{126, 125}
  };

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_preceding;
    logic [6:0]  new_ctx_state;
    logic [23:0] byte_position;
    logic [1:0]  status;
    logic        last;
  } coded_result_t;

  // Coder state
  logic [19:0] low;
  logic [8:0]  coder_range;
  int          bits_queued;
  int unsigned run_len;
  logic [7:0]  held_byte;
  bit          held_is_preceding;
  bit          finished;
  logic [31:0] bytes_written;

  // Bytes produced by the current item
  logic [7:0]  item_bytes [32];
  bit          item_pre [32];
  int          item_n;
  bit          run_overflow;

  coded_result_t coded_results[$];
  int            errors = 0;

  function automatic void push_byte(logic [7:0] b, bit pre);
    if (item_n < 32) begin
      item_bytes[item_n] = b;
      item_pre[item_n] = pre;
      item_n++;
    end
  endfunction

  // Move one byte out of low: hold it, count it as 0xFF run, or release with carry
  function automatic void resolve_byte();
    logic [31:0] v;
    logic [31:0] carry;
    int unsigned q;
    if (bits_queued < 0 || bits_queued > 15) return;
    q = bits_queued;
    v = {12'b0, low} >> (q + 10);
    low = low & 20'((32'h400 << q) - 1);
    bits_queued -= 8;
    if (v[7:0] == 8'hFF) begin
      if (run_len < OUTSTANDING_LIMIT) run_len++;
      else run_overflow = 1'b1;
      return;
    end
    carry = (v >> 8) & 32'hFF;
    push_byte(8'(held_byte + carry), held_is_preceding);
    while (run_len > 0) begin
      push_byte(8'(carry - 1), 1'b0);
      run_len--;
      bytes_written++;
    end
    held_byte = v[7:0];
    held_is_preceding = 1'b0;
    bytes_written = (bytes_written + 1) & POS_MASK;
  endfunction

  function automatic void renormalize();
    logic [5:0] idx;
    int sh;
    idx = coder_range[8:3];
    sh = 0;
    while (idx < 6'd32 && sh < 6) begin
      idx = idx << 1;
      sh++;
    end
    coder_range = coder_range << sh;
    low = low << sh;
    bits_queued += sh;
    resolve_byte();
  endfunction

  // Flush the interval, append the stop bit and release everything held
  function automatic void flush_coder(logic [4:0] fi);
    int sh;
    low = low + {11'b0, coder_range} - 20'd2;
    low[0] = 1'b1;
    low = low << 9;
    bits_queued += 9;
    resolve_byte();
    resolve_byte();
    sh = (bits_queued < 0) ? -bits_queued : 0;
    if (sh > 20) sh = 20;
    low = low << sh;
    low[10] = low[10] | STOP_BITS[fi];
    bits_queued = 0;
    resolve_byte();
    push_byte(held_byte, held_is_preceding);
    while (run_len > 0) begin
      push_byte(8'hFF, 1'b0);
      run_len--;
      bytes_written++;
    end
    bytes_written = bytes_written & POS_MASK;
    finished = 1'b1;
  endfunction

  function automatic void encode_item(cabac_pkg::op_t op, logic b, logic [6:0] st,
                                      logic [4:0] fi);
    logic [7:0]    lps;
    logic [6:0]    nst;
    logic [1:0]    stat;
    logic [23:0]   pos;
    int            n;
    coded_result_t r;
    nst = st;
    stat = cabac_pkg::STATUS_OK;
    item_n = 0;
    run_overflow = 1'b0;
    if (finished) begin
      stat = cabac_pkg::STATUS_REJECTED;
    end else begin
      case (op)
        cabac_pkg::OP_DECISION: begin
          lps = LPS_RANGE[st[6:1]][coder_range[7:6]];
          coder_range = coder_range - {1'b0, lps};
          if (b != st[0]) begin
            low = low + {11'b0, coder_range};
            coder_range = {1'b0, lps};
          end
          nst = NEXT_STATE[st][b];
          renormalize();
        end
        cabac_pkg::OP_BYPASS: begin
          low = low << 1;
          if (b) low = low + {11'b0, coder_range};
          bits_queued++;
          resolve_byte();
        end
        cabac_pkg::OP_TERMINATE: begin
          coder_range = coder_range - 9'd2;
          renormalize();
        end
        default: begin
          flush_coder(fi);
        end
      endcase
    end
    if (stat == cabac_pkg::STATUS_OK && run_overflow) stat = cabac_pkg::STATUS_OVERFLOW;
    pos = 24'((bytes_written + run_len) & POS_MASK);
    n = (item_n < MAX_PER_ITEM) ? item_n : MAX_PER_ITEM;
    r.new_ctx_state = nst;
    r.byte_position = pos;
    r.status = stat;
    if (n == 0) begin
      r.out_byte = 8'h00;
      r.byte_valid = 1'b0;
      r.is_preceding = 1'b0;
      r.last = 1'b1;
      coded_results = {coded_results, r};
    end else begin
      for (int k = 0; k < n; k++) begin
        r.out_byte = item_bytes[k];
        r.byte_valid = 1'b1;
        r.is_preceding = item_pre[k];
        r.last = (k == n - 1);
        coded_results = {coded_results, r};
      end
    end
  endfunction

  // Predict on each command transaction, compare on each result transaction
  always @(posedge clk) begin
    coded_result_t want;
    coded_result_t got;
    if (rst) begin
      low = '0;
      coder_range = 9'd510;
      bits_queued = -9;
      run_len = 0;
      held_byte = 8'h00;
      held_is_preceding = 1'b1;
      finished = 1'b0;
      bytes_written = '0;
      coded_results.delete();
    end else begin
      if (cfg_we) begin
        if (held_is_preceding) held_byte = cfg_data;
      end
      if (cmd.valid && cmd.ready) begin
        encode_item(cabac_pkg::op_t'(cmd.op), cmd.bin, cmd.ctx_state, cmd.frame_index);
      end
      if (res.valid && res.ready) begin
        got.out_byte = res.out_byte;
        got.byte_valid = res.byte_valid;
        got.is_preceding = res.is_preceding;
        got.new_ctx_state = res.new_ctx_state;
        got.byte_position = res.byte_position;
        got.status = res.status;
        got.last = res.last;
        if (coded_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: expected none, actual byte=%02h",
                   $time, got.out_byte);
        end else begin
          want = coded_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected byte=%02h bv=%0d pre=%0d ctx=%0d pos=%0d st=%0d last=%0d",
                     $time, want.out_byte, want.byte_valid, want.is_preceding,
                     want.new_ctx_state, want.byte_position, want.status, want.last);
            $display("%0t: actual   byte=%02h bv=%0d pre=%0d ctx=%0d pos=%0d st=%0d last=%0d",
                     $time, got.out_byte, got.byte_valid, got.is_preceding,
                     got.new_ctx_state, got.byte_position, got.status, got.last);
          end
        end
      end
    end
    mismatch_count <= errors;
    results_in_flight <= coded_results.size();
  end

endmodule

### bench/tb_cabac_binary_arithmetic_encoder_core.sv
module tb_cabac_binary_arithmetic_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int RANDOM_ITEMS      = 250;
  localparam int LONG_STALL_AT     = 100;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES      = 40;
  // shapes of the random segments
  localparam int SHAPE_NOISE       = 0;
  localparam int SHAPE_MPS         = 4;
  localparam int SHAPE_UPPER       = 7;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  int         cycle_count = 0;
  int         mismatch_count;
  int         results_in_flight;
  int         send_quiet = 0;

  cabac_cmd_if cmd_if ();
  cabac_res_if res_if ();

  cabac_binary_arithmetic_encoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_if),
    .res      (res_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  cabac_stream_checker stream_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .cmd               (cmd_if),
    .res               (res_if),
    .mismatch_count    (mismatch_count),
    .results_in_flight (results_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Gap before the next transaction, with occasional stretches of none
  function automatic int pick_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic offer_item(cabac_pkg::op_t op, logic b, logic [6:0] st, logic [4:0] fi);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.op <= op;
    cmd_if.bin <= b;
    cmd_if.ctx_state <= st;
    cmd_if.frame_index <= fi;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
  endtask

  // Random item of a given segment shape
  task automatic offer_shaped(int shape);
    logic [6:0]     st;
    logic           b;
    cabac_pkg::op_t op;
    st = 7'($urandom_range(0, 127));
    b = 1'($urandom_range(0, 1));
    op = cabac_pkg::op_t'($urandom_range(0, 2));
    if (shape >= SHAPE_UPPER) begin
      // keep taking the upper subinterval so 0xFF bytes pile up
      if ($urandom_range(0, 5) == 0) begin
        op = cabac_pkg::OP_BYPASS;
        b = 1'b1;
      end else begin
        op = cabac_pkg::OP_DECISION;
        st = 7'($urandom_range(2, 11));
        b = ~st[0];
      end
    end else if (shape >= SHAPE_MPS) begin
      op = cabac_pkg::OP_DECISION;
      if ($urandom_range(0, 7) != 0) b = st[0];
    end
    offer_item(op, b, st, 5'($urandom));
  endtask

  // Hold the input until every pending result has left
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (results_in_flight != 0);
  endtask

  task automatic write_setting(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls plus one long hold-off to back up the input
  initial begin
    int gap;
    int quiet;
    int taken;
    quiet = 0;
    taken = 0;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap(quiet);
      if (taken == LONG_STALL_AT) gap = LONG_STALL_CYCLES;
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      taken++;
    end
  end

  // Stimulus
  initial begin
    int shape;
    int len;
    int sent;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= 8'h00;
    cmd_if.valid <= 1'b0;
    cmd_if.op <= cabac_pkg::OP_DECISION;
    cmd_if.bin <= 1'b0;
    cmd_if.ctx_state <= 7'd0;
    cmd_if.frame_index <= 5'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, decision, bypass and terminate bins, degenerate states, held preceding byte
    write_setting(8'h00);
    offer_item(cabac_pkg::OP_BYPASS, 1'b0, 7'd0, 5'd0);
    offer_item(cabac_pkg::OP_BYPASS, 1'b1, 7'd127, 5'd31);
    wait_drained();
    write_setting(8'hFF);
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd127, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd126, 5'd0);
    offer_item(cabac_pkg::OP_TERMINATE, 1'b0, 7'd0, 5'd0);
    offer_item(cabac_pkg::OP_BYPASS, 1'b1, 7'd0, 5'd0);
    offer_item(cabac_pkg::OP_BYPASS, 1'b1, 7'd0, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd0, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b0, 7'd1, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b0, 7'd0, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd1, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b0, 7'd64, 5'd21);
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd65, 5'd10);
    offer_item(cabac_pkg::OP_TERMINATE, 1'b1, 7'd127, 5'd31);
    wait_drained();
    write_setting(8'($urandom_range(1, 254)));
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd2, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b0, 7'd3, 5'd0);
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd4, 5'd0);
    offer_item(cabac_pkg::OP_BYPASS, 1'b0, 7'd85, 5'd17);

    // Random segments: noise, mostly-MPS decisions, upper-subinterval runs
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      shape = $urandom_range(0, 9);
      len = (shape >= SHAPE_UPPER) ? $urandom_range(30, 45) : $urandom_range(8, 24);
      repeat (len) begin
        offer_shaped(shape);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        write_setting(8'($urandom_range(0, 255)));
      end
    end

    // Build a long 0xFF run so the flush releases the most bytes
    repeat (30) offer_shaped(SHAPE_UPPER);
    offer_item(cabac_pkg::OP_FINISH, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
               5'($urandom));

    // Everything after the flush is rejected
    wait_drained();
    write_setting(8'($urandom_range(0, 255)));
    offer_item(cabac_pkg::OP_DECISION, 1'b1, 7'd50, 5'd3);
    offer_item(cabac_pkg::OP_BYPASS, 1'b1, 7'd7, 5'd0);
    offer_item(cabac_pkg::OP_TERMINATE, 1'b0, 7'd0, 5'd31);
    offer_item(cabac_pkg::OP_FINISH, 1'b0, 7'd127, 5'd12);
    offer_shaped(SHAPE_NOISE);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_in_flight == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
